[hdl/ptw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// shared types, codes and helpers of the page table walker
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int MaxLevels = 5;
  localparam int PnBits    = 44;
  localparam int LvlW      = 3;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_RESP  = 2'd1,
    ACT_ACK   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RES_READ  = 2'd0,
    RES_WRITE = 2'd1,
    RES_DONE  = 2'd2,
    RES_FAULT = 2'd3
  } result_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CFG_MODE = 3'd0,
    CFG_ROOT = 3'd1,
    CFG_SUM  = 3'd2,
    CFG_MXR  = 3'd3,
    CFG_ADUE = 3'd4,
    CFG_EXT  = 3'd5,
    CFG_PMM  = 3'd6,
    CFG_MPRV = 3'd7
  } cfg_idx_e;

  localparam logic [2:0] KIND_FETCH = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_STORE = 3'd2;
  localparam logic [2:0] KIND_AMO   = 3'd3;
  localparam logic [2:0] KIND_CBO   = 3'd4;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  // configuration snapshot
  typedef struct packed {
    logic [3:0]        mode;
    logic [PnBits-1:0] root;
    logic              sum;
    logic              mxr;
    logic              adue;
    logic [3:0]        ext;
    logic [3:0]        pmm;
    logic [2:0]        mbr;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] va;
    logic [2:0]  kind;
    logic [1:0]  priv;
    logic [63:0] entry;
    logic        merr;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [55:0] req_addr;
    logic [63:0] req_data;
    logic [63:0] pa;
    logic [2:0]  fcode;
    logic [63:0] fval;
  } res_t;

  function automatic logic [63:0] sext_at(input logic [63:0] v, input logic [6:0] bits);
    logic [63:0] r;
    r = v;
    for (int i = 0; i < 64; i++) begin
      if (i >= int'(bits)) r[i] = v[int'(bits) - 1];
    end
    return r;
  endfunction

  function automatic logic [2:0] fault_code(input logic [2:0] kind, input logic acc);
    logic [2:0] c;
    c = (kind == KIND_FETCH) ? 3'd1 : ((kind == KIND_LOAD) ? 3'd2 : 3'd3);
    return acc ? c + 3'd3 : c;
  endfunction

endpackage
`default_nettype wire

[hdl/ptw_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module ptw_queue import ptw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      push_data_i,
  output logic       full_o,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output item_t      pop_data_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

[hdl/ptw_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_back
// walk state machine: start checks, entry checks, result register
// ----------------------------------------------------------------------------
module ptw_back import ptw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic item_valid_i,
  input  item_t     item_i,
  output logic      item_pop_o,
  output logic      res_valid_o,
  output res_t      res_o,
  input  wire logic res_stall_i
);

  phase_e      phase_q, phase_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [43:0] base_q, base_d;
  logic [63:0] sva_q, sva_d;
  logic [2:0]  skind_q, skind_d;
  logic [1:0]  spriv_q, spriv_d;
  logic [63:0] leaf_q, leaf_d;
  logic [55:0] laddr_q, laddr_d;
  logic        rv_q, rv_d;
  res_t        res_q, res_d;

  logic take;
  assign take        = item_valid_i && (!rv_q || !res_stall_i);
  assign item_pop_o  = take;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  function automatic logic [55:0] entry_addr(input logic [43:0] b, input logic [63:0] va,
                                             input logic [LvlW-1:0] l);
    logic [63:0] sh;
    logic [8:0]  idx;
    sh  = va >> (7'd12 + 7'd9 * {4'd0, l});
    idx = sh[8:0];
    return {b, 12'd0} + {44'd0, idx, 3'd0};
  endfunction

  always_comb begin
    logic [63:0] va, e, pa, mask, need, ppn64;
    logic [1:0]  pmm, eff;
    logic [2:0]  lv;
    logic [43:0] ppn;
    logic        ok, fault, pbmt_on, emit;
    logic [1:0]  mt;
    phase_d = phase_q; lvl_d = lvl_q; base_d = base_q; sva_d = sva_q;
    skind_d = skind_q; spriv_d = spriv_q; leaf_d = leaf_q; laddr_d = laddr_q;
    rv_d = rv_q && res_stall_i; res_d = res_q;
    va = '0; e = '0; pa = '0; mask = '0; need = '0; ppn64 = '0; pmm = '0; eff = '0;
    lv = '0; ppn = '0; ok = 1'b0; fault = 1'b0; mt = '0; emit = 1'b0;
    pbmt_on = cfg_i.ext[0] && cfg_i.ext[2];
    res_d.req_addr = res_q.req_addr;
    if (take) begin
      emit = 1'b0;
      res_d = '0;
      case (action_e'(item_i.action))
        ACT_START: begin
          va = item_i.va;
          eff = item_i.priv;
          if (item_i.kind != KIND_FETCH && cfg_i.ext[3]) begin
            if (item_i.priv == PRIV_U) pmm = cfg_i.pmm[3:2];
            else if (item_i.priv == PRIV_S) pmm = cfg_i.pmm[1:0];
            if (pmm == 2'd2) va = sext_at(va, 7'd57);
            else if (pmm == 2'd3) va = sext_at(va, 7'd48);
          end
          if (item_i.kind != KIND_FETCH && item_i.priv == PRIV_M && cfg_i.mbr[2])
            eff = cfg_i.mbr[1:0];
          sva_d = va; skind_d = item_i.kind; spriv_d = eff; phase_d = PH_IDLE;
          lv = (cfg_i.mode == 4'd8) ? 3'd3 : (cfg_i.mode == 4'd9) ? 3'd4 :
               (cfg_i.mode == 4'd10) ? 3'd5 : 3'd0;
          emit = 1'b1;
          if (eff == PRIV_M || cfg_i.mode == 4'd0 || lv == 3'd0 ||
              int'(lv) > MaxLevels) begin
            res_d.kind = RES_DONE; res_d.pa = va;
          end else if (sext_at(va, 7'd12 + 7'd9 * {4'd0, lv}) != va) begin
            res_d.kind = RES_FAULT; res_d.fcode = fault_code(item_i.kind, 1'b0);
            res_d.fval = va;
          end else begin
            lvl_d = lv - 3'd1;
            base_d = cfg_i.root;
            phase_d = PH_READ;
            res_d.kind = RES_READ;
            res_d.req_addr = entry_addr(cfg_i.root, va, lv - 3'd1);
          end
        end
        ACT_RESP: if (phase_q == PH_READ) begin
          emit = 1'b1;
          e = item_i.entry;
          phase_d = PH_IDLE;
          mt = e[62:61];
          ppn = e[53:10];
          fault = 1'b0;
          if (item_i.merr) begin
            res_d.kind = RES_FAULT; res_d.fcode = fault_code(skind_q, 1'b1);
            res_d.fval = sva_q;
          end else begin
            if (!e[0] || (!e[1] && e[2]) || (e[60:54] != 7'd0)) fault = 1'b1;
            else if (e[1] || e[3]) begin
              laddr_d = entry_addr(base_q, sva_q, lvl_q);
              if (mt == 2'd3 || (mt != 2'd0 && !pbmt_on)) fault = 1'b1;
              case (skind_q)
                KIND_FETCH: ok = e[3];
                KIND_LOAD:  ok = e[1] || (cfg_i.mxr && e[3]);
                KIND_STORE: ok = e[2];
                KIND_AMO:   ok = e[1] && e[2];
                KIND_CBO:   ok = e[1] || e[2];
                default:    ok = 1'b0;
              endcase
              if (!ok) fault = 1'b1;
              if (spriv_q == PRIV_U) begin
                if (!e[4]) fault = 1'b1;
              end else if (e[4] && (skind_q == KIND_FETCH || !cfg_i.sum)) fault = 1'b1;
              if (e[63] && (!cfg_i.ext[1] || lvl_q != 3'd0 || ppn[3:0] != 4'h8))
                fault = 1'b1;
              mask = (64'd1 << (7'd9 * {4'd0, lvl_q})) - 64'd1;
              if (lvl_q != 3'd0 && (({20'd0, ppn} & mask) != 64'd0)) fault = 1'b1;
              need = 64'h40;
              if (skind_q == KIND_STORE || skind_q == KIND_AMO) need = 64'hC0;
              if (!fault) begin
                leaf_d = e;
                if ((e & need) != need) begin
                  if (!cfg_i.adue) fault = 1'b1;
                  else begin
                    leaf_d = e | need;
                    phase_d = PH_WRITE;
                    res_d.kind = RES_WRITE;
                    res_d.req_addr = entry_addr(base_q, sva_q, lvl_q);
                    res_d.req_data = e | need;
                  end
                end else begin
                  if (e[63]) ppn = {ppn[43:4], sva_q[15:12]};
                  ppn64 = {8'd0, ppn, 12'd0};
                  mask = (64'd1 << (7'd12 + 7'd9 * {4'd0, lvl_q})) - 64'd1;
                  res_d.kind = RES_DONE;
                  res_d.pa = ppn64 | (sva_q & mask);
                end
              end
            end else begin
              if ((e[7:6] != 2'd0) || e[4] || e[63] || mt != 2'd0) fault = 1'b1;
              else if (lvl_q == 3'd0) fault = 1'b1;
              else begin
                base_d = ppn;
                lvl_d = lvl_q - 3'd1;
                phase_d = PH_READ;
                res_d.kind = RES_READ;
                res_d.req_addr = entry_addr(ppn, sva_q, lvl_q - 3'd1);
              end
            end
            if (fault) begin
              res_d = '0;
              res_d.kind = RES_FAULT; res_d.fcode = fault_code(skind_q, 1'b0);
              res_d.fval = sva_q;
            end
          end
        end
        ACT_ACK: if (phase_q == PH_WRITE) begin
          emit = 1'b1;
          phase_d = PH_IDLE;
          if (item_i.merr) begin
            res_d.kind = RES_FAULT; res_d.fcode = fault_code(skind_q, 1'b1);
            res_d.fval = sva_q;
          end else begin
            ppn = leaf_q[53:10];
            if (leaf_q[63]) ppn = {ppn[43:4], sva_q[15:12]};
            mask = (64'd1 << (7'd12 + 7'd9 * {4'd0, lvl_q})) - 64'd1;
            res_d.kind = RES_DONE;
            res_d.pa = {8'd0, ppn, 12'd0} | (sva_q & mask);
          end
        end
        default: emit = 1'b0;
      endcase
      if (emit) rv_d = 1'b1;
      else res_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lvl_q   <= '0;
      rv_q    <= 1'b0;
      base_q  <= '0;
      sva_q   <= '0;
      skind_q <= '0;
      spriv_q <= '0;
      leaf_q  <= '0;
      laddr_q <= '0;
    end else begin
      phase_q <= phase_d;
      lvl_q   <= lvl_d;
      rv_q    <= rv_d;
      base_q  <= base_d;
      sva_q   <= sva_d;
      skind_q <= skind_d;
      spriv_q <= spriv_d;
      leaf_q  <= leaf_d;
      laddr_q <= laddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
`default_nettype wire

[hdl/page_table_walker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// a request is held in the queue, then the walk stage registers its result and offers
// it until it is taken
// throughput: one request per cycle unless the result channel stalls, set by the
// single walk stage in the back end; a pointer response advances the walk one level
// reset: asynchronous active low; walk idle, queue empty, config and walk state zero
// ----------------------------------------------------------------------------
// page_table_walker_core
// sv39/sv48/sv57 walker: front intake, two-entry queue, walk back end
// ----------------------------------------------------------------------------
module page_table_walker_core import ptw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] virtual_address_i,
  input  wire logic [2:0]  access_kind_i,
  input  wire logic [1:0]  privilege_i,
  input  wire logic [63:0] entry_value_i,
  input  wire logic        memory_error_i,
  // result channel
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       result_kind_o,
  output logic [55:0]      request_address_o,
  output logic [63:0]      request_data_o,
  output logic [63:0]      physical_address_o,
  output logic [2:0]       fault_code_o,
  output logic [63:0]      fault_value_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_full, q_valid, q_pop;
  res_t  res;

  // config is always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE: cfg_q.mode <= cfg_data_i[3:0];
        CFG_ROOT: cfg_q.root <= cfg_data_i[PnBits-1:0];
        CFG_SUM:  cfg_q.sum  <= cfg_data_i[0];
        CFG_MXR:  cfg_q.mxr  <= cfg_data_i[0];
        CFG_ADUE: cfg_q.adue <= cfg_data_i[0];
        CFG_EXT:  cfg_q.ext  <= cfg_data_i[3:0];
        CFG_PMM:  cfg_q.pmm  <= cfg_data_i[3:0];
        CFG_MPRV: cfg_q.mbr  <= cfg_data_i[2:0];
        default:  cfg_q.mode <= cfg_q.mode;
      endcase
    end
  end

  // front: bundle the request
  assign in_item = '{action: action_i, va: virtual_address_i, kind: access_kind_i,
                     priv: privilege_i, entry: entry_value_i, merr: memory_error_i};
  assign stall_o = q_full;

  ptw_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (valid_i && !q_full),
    .push_data_i (in_item),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_item)
  );

  ptw_back u_back (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (valid_o),
    .res_o        (res),
    .res_stall_i  (stall_i)
  );

  assign result_kind_o      = res.kind;
  assign request_address_o  = res.req_addr;
  assign request_data_o     = res.req_data;
  assign physical_address_o = res.pa;
  assign fault_code_o       = res.fcode;
  assign fault_value_o      = res.fval;

endmodule
`default_nettype wire

[hdl/ptw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_checker
// port-level checks of the walker
// ----------------------------------------------------------------------------
module ptw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [2:0]  fault_code_o,
  input wire logic [63:0] request_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_kind_o))
    else $error("result dropped under stall");

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_kind_o == 2'd3 |-> fault_code_o != 3'd0)
    else $error("fault without code");

  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_kind_o != 2'd3 |-> fault_code_o == 3'd0)
    else $error("code on non-fault");

  a_wb_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_kind_o == 2'd1 |-> request_data_o[6])
    else $error("write-back without accessed bit");

endmodule

bind page_table_walker_core ptw_checker u_ptw_checker (.*);
`default_nettype wire

[tb/sv/page_table_walker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walker_core_tb
// drives walks (start, table responses, write-back acks) and noise through
// the walker under a range of mode and extension settings, predicts every
// read, write, done and fault result, and checks them in order
// ----------------------------------------------------------------------------

import ptw_pkg::*;

// expected results of the walker, computed at request acceptance
class walk_scoreboard;

  // register copies
  logic [3:0]  mode;
  logic [43:0] root;
  logic        sum, mxr, adue;
  logic [3:0]  ext, pmm;
  logic [2:0]  mbr;

  // walk state
  phase_e      phase;
  int unsigned lvl;
  logic [43:0] base;
  logic [63:0] vaddr, leaf_e;
  logic [55:0] leaf_addr;
  logic [2:0]  kind;
  logic [1:0]  walk_priv;

  res_t        expected_q[$];
  int          errors, n_read, n_write, n_done, n_fault;

  function new();
    mode = '0; root = '0; sum = 0; mxr = 0; adue = 0; ext = '0; pmm = '0; mbr = '0;
    phase = PH_IDLE; lvl = 0; base = '0; vaddr = '0; leaf_e = '0; leaf_addr = '0;
    kind = '0; walk_priv = '0; errors = 0;
    n_read = 0; n_write = 0; n_done = 0; n_fault = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [63:0] d);
    case (idx)
      CFG_MODE: mode = d[3:0];
      CFG_ROOT: root = d[43:0];
      CFG_SUM:  sum  = d[0];
      CFG_MXR:  mxr  = d[0];
      CFG_ADUE: adue = d[0];
      CFG_EXT:  ext  = d[3:0];
      CFG_PMM:  pmm  = d[3:0];
      default:  mbr  = d[2:0];
    endcase
  endfunction

  function logic [63:0] sign_fill(logic [63:0] v, int unsigned n);
    logic [63:0] m;
    if (n >= 64) return v;
    m = 64'd1 << (n - 1);
    v = v & ((64'd1 << n) - 64'd1);
    return (v ^ m) - m;
  endfunction

  function void push(result_e k, logic [55:0] ra, logic [63:0] rd, logic [63:0] pa,
                     logic [2:0] fc, logic [63:0] fv);
    res_t r;
    r.kind = k; r.req_addr = ra; r.req_data = rd; r.pa = pa; r.fcode = fc; r.fval = fv;
    expected_q.push_back(r);
    case (k)
      RES_READ:  n_read++;
      RES_WRITE: n_write++;
      RES_DONE:  n_done++;
      default:   n_fault++;
    endcase
  endfunction

  function void walk_fault(bit acc);
    logic [2:0] c;
    c = (kind == KIND_FETCH) ? 3'd1 : ((kind == KIND_LOAD) ? 3'd2 : 3'd3);
    if (acc) c = c + 3'd3;
    phase = PH_IDLE;
    push(RES_FAULT, '0, '0, '0, c, vaddr);
  endfunction

  function logic [55:0] entry_addr();
    logic [63:0] idx, a;
    idx = (vaddr >> (12 + 9 * lvl)) & 64'h1FF;
    a = ({20'b0, base} << 12) + idx * 8;
    return a[55:0];
  endfunction

  function void table_read();
    phase = PH_READ;
    push(RES_READ, entry_addr(), '0, '0, '0, '0);
  endfunction

  function void walk_done();
    logic [43:0] ppn;
    logic [63:0] m;
    ppn = leaf_e[53:10];
    if (leaf_e[63]) ppn[3:0] = vaddr[15:12];
    m = (64'd1 << (12 + 9 * lvl)) - 64'd1;
    phase = PH_IDLE;
    push(RES_DONE, '0, '0, ({20'b0, ppn} << 12) | (vaddr & m), '0, '0);
  endfunction

  function void begin_walk(item_t it);
    logic [63:0] va;
    logic [1:0]  pm;
    int unsigned cut, lv;
    va = it.va;
    walk_priv = it.priv;
    // pointer masking applies to data accesses only
    if (it.kind != KIND_FETCH && ext[3]) begin
      pm = (it.priv == PRIV_U) ? pmm[3:2] : ((it.priv == PRIV_S) ? pmm[1:0] : 2'd0);
      cut = (pm == 2'd2) ? 7 : ((pm == 2'd3) ? 16 : 0);
      if (cut != 0) va = sign_fill(va, 64 - cut);
    end
    // machine-mode privilege borrowing
    if (it.kind != KIND_FETCH && it.priv == PRIV_M && mbr[2]) walk_priv = mbr[1:0];
    vaddr = va;
    kind = it.kind;
    phase = PH_IDLE;
    lv = (mode == 4'd8) ? 3 : (mode == 4'd9) ? 4 : (mode == 4'd10) ? 5 : 0;
    if (walk_priv == PRIV_M || mode == 4'd0 || lv == 0) begin
      push(RES_DONE, '0, '0, va, '0, '0);
    end else if (sign_fill(va, 12 + 9 * lv) != va) begin
      walk_fault(0);
    end else begin
      lvl = lv - 1;
      base = root;
      table_read();
    end
  endfunction

  function void leaf_check(logic [63:0] e);
    bit ok;
    logic [63:0] need;
    logic [43:0] ppn;
    if (e[62:61] == 2'd3 || (e[62:61] != 2'd0 && !(ext[0] && ext[2]))) begin
      walk_fault(0);
      return;
    end
    case (kind)
      KIND_FETCH: ok = e[3];
      KIND_LOAD:  ok = e[1] || (mxr && e[3]);
      KIND_STORE: ok = e[2];
      KIND_AMO:   ok = e[1] && e[2];
      KIND_CBO:   ok = e[1] || e[2];
      default:    ok = 0;
    endcase
    // user mode needs user pages; others: no fetch from user pages, data only with sum
    if (walk_priv == PRIV_U) ok = ok && e[4];
    else if (e[4] && (kind == KIND_FETCH || !sum)) ok = 0;
    ppn = e[53:10];
    if (e[63] && (!ext[1] || lvl != 0 || ppn[3:0] != 4'h8)) ok = 0;
    if (lvl > 0 && ({20'b0, ppn} & ((64'd1 << (9 * lvl)) - 64'd1)) != 0) ok = 0;
    if (!ok) begin
      walk_fault(0);
      return;
    end
    leaf_e = e;
    need = 64'h40;
    if (kind == KIND_STORE || kind == KIND_AMO) need = need | 64'h80;
    if ((e & need) != need) begin
      if (!adue) begin
        walk_fault(0);
        return;
      end
      leaf_e = e | need;
      phase = PH_WRITE;
      push(RES_WRITE, leaf_addr, leaf_e, '0, '0, '0);
    end else begin
      walk_done();
    end
  endfunction

  function void table_response(item_t it);
    logic [63:0] e;
    e = it.entry;
    if (it.merr) walk_fault(1);
    else if (!e[0] || (!e[1] && e[2]) || e[60:54] != '0) walk_fault(0);
    else if (e[1] || e[3]) begin
      leaf_addr = entry_addr();
      leaf_check(e);
    end else if (e[7:6] != '0 || e[4] || e[63:61] != '0 || lvl == 0) walk_fault(0);
    else begin
      base = e[53:10];
      lvl--;
      table_read();
    end
  endfunction

  function void note_request(item_t it);
    if (it.action == ACT_START) begin_walk(it);
    else if (it.action == ACT_RESP && phase == PH_READ) table_response(it);
    else if (it.action == ACT_ACK && phase == PH_WRITE) begin
      if (it.merr) walk_fault(1);
      else walk_done();
    end
  endfunction

  function void check_result(res_t got);
    res_t w;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: kind %0d", got.kind);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    if (got.kind != w.kind) begin
      $error("result_kind: expected %0d, got %0d", w.kind, got.kind); errors++;
    end
    if (got.req_addr != w.req_addr) begin
      $error("request_address: expected %h, got %h", w.req_addr, got.req_addr); errors++;
    end
    if (got.req_data != w.req_data) begin
      $error("request_data: expected %h, got %h", w.req_data, got.req_data); errors++;
    end
    if (got.pa != w.pa) begin
      $error("physical_address: expected %h, got %h", w.pa, got.pa); errors++;
    end
    if (got.fcode != w.fcode) begin
      $error("fault_code: expected %0d, got %0d", w.fcode, got.fcode); errors++;
    end
    if (got.fval != w.fval) begin
      $error("fault_value: expected %h, got %h", w.fval, got.fval); errors++;
    end
  endfunction
endclass

module page_table_walker_core_tb;
  import ptw_pkg::*;

  localparam int IdleLimit = 3000;

  logic        clk_i, rst_ni;
  logic        valid_i, stall_i, cfg_valid_i;
  logic [1:0]  action_i, privilege_i;
  logic [63:0] virtual_address_i, entry_value_i, cfg_data_i;
  logic [2:0]  access_kind_i, cfg_index_i;
  logic        memory_error_i;
  logic        stall_o, valid_o, cfg_ready_o;
  logic [1:0]  result_kind_o;
  logic [55:0] request_address_o;
  logic [63:0] request_data_o, physical_address_o, fault_value_o;
  logic [2:0]  fault_code_o;

  walk_scoreboard sb = new();
  item_t  cur;          // request currently offered
  int     n_sent;
  bit     calm;         // no idling on either side
  int     hold_off;     // receiver stall stretch, counted in its own process
  int     quiet_cycles;

  page_table_walker_core dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // all inputs known from time zero, reset held low and then released
  initial begin
    rst_ni = 0;
    valid_i = 0; action_i = '0; virtual_address_i = '0; access_kind_i = '0;
    privilege_i = '0; entry_value_i = '0; memory_error_i = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    stall_i = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        stall_i <= 1;
        hold_off--;
      end else begin
        stall_i <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && valid_o && !stall_i) begin
      got.kind = result_kind_o; got.req_addr = request_address_o;
      got.req_data = request_data_o; got.pa = physical_address_o;
      got.fcode = fault_code_o; got.fval = fault_value_o;
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("** page_table_walker_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request and hold it until accepted; valid stays high afterwards
  task automatic offer(item_t it);
    if (!calm && $urandom_range(99) < 26) begin
      valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cur = it;
    valid_i <= 1;
    action_i <= it.action; virtual_address_i <= it.va; access_kind_i <= it.kind;
    privilege_i <= it.priv; entry_value_i <= it.entry; memory_error_i <= it.merr;
    do @(posedge clk_i); while (stall_o);
    sb.note_request(cur);
    n_sent++;
  endtask

  // wait until the walker has nothing left to say, then settle
  task automatic drain();
    valid_i <= 0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [3:0] md, logic [43:0] rt, logic s, logic m, logic a,
                         logic [3:0] ex, logic [3:0] pm, logic [2:0] mb);
    drain();
    write_reg(CFG_MODE, {$urandom, $urandom} & ~64'hF | md);
    write_reg(CFG_ROOT, {20'b0, rt});
    write_reg(CFG_SUM, s);
    write_reg(CFG_MXR, m);
    write_reg(CFG_ADUE, a);
    write_reg(CFG_EXT, ex);
    write_reg(CFG_PMM, pm);
    write_reg(CFG_MPRV, mb);
  endtask

  function automatic item_t mk(action_e a, logic [63:0] va, logic [2:0] k, logic [1:0] p,
                               logic [63:0] e, logic me);
    item_t it;
    it.action = a; it.va = va; it.kind = k; it.priv = p; it.entry = e; it.merr = me;
    return it;
  endfunction

  // table entry aimed at the current walk level: mostly pointers above the last level, leaves otherwise
  function automatic logic [63:0] pick_entry();
    logic [63:0] e;
    e = {$urandom, $urandom};
    if (sb.lvl > 0 && $urandom_range(99) < 65) begin
      e[7:0] = 8'h01;
      e[63:54] = '0;
      if ($urandom_range(99) < 8) e[7:4] = $urandom;
    end else begin
      e[0] = $urandom_range(99) < 95;
      e[3:1] = $urandom;
      if (e[2] && $urandom_range(99) < 80) e[1] = 1;
      e[7:6] = $urandom_range(99) < 60 ? 2'b11 : $urandom;
      e[4] = $urandom;
      // superpage alignment usually honored
      if (sb.lvl > 0 && $urandom_range(99) < 85)
        e[53:10] = e[53:10] & ~((44'd1 << (9 * sb.lvl)) - 44'd1);
      e[63] = $urandom_range(99) < 10;
      if (e[63] && $urandom_range(99) < 70) e[13:10] = 4'h8;
      e[62:61] = $urandom_range(99) < 15 ? $urandom : 2'd0;
      if ($urandom_range(99) >= 6) e[60:54] = '0;
    end
    return e;
  endfunction

  // one walk: start, then responses and acks as the walker asks for them,
  // with the odd stray or dropping request mixed in
  task automatic run_walk();
    logic [63:0] va;
    int lv, steps;
    va = {$urandom, $urandom};
    lv = (sb.mode == 4'd9) ? 4 : (sb.mode == 4'd10) ? 5 : 3;
    if ($urandom_range(99) < 85) va = sb.sign_fill(va, 12 + 9 * lv);
    offer(mk(ACT_START, va, $urandom_range(99) < 6 ? $urandom_range(5, 7) :
             $urandom_range(0, 4), $urandom, $urandom, $urandom));
    steps = 0;
    while (sb.phase != PH_IDLE && steps < 8) begin
      steps++;
      if ($urandom_range(99) < 4) begin
        offer(mk(action_e'($urandom), {$urandom, $urandom}, $urandom, $urandom,
                 {$urandom, $urandom}, $urandom));
      end else if (sb.phase == PH_READ) begin
        offer(mk(ACT_RESP, {$urandom, $urandom}, $urandom, $urandom, pick_entry(),
                 $urandom_range(99) < 4));
      end else begin
        offer(mk(ACT_ACK, {$urandom, $urandom}, $urandom, $urandom, {$urandom, $urandom},
                 $urandom_range(99) < 10));
      end
    end
    if ($urandom_range(99) < 8)
      offer(mk(action_e'($urandom_range(1, 3)), {$urandom, $urandom}, $urandom, $urandom,
               {$urandom, $urandom}, $urandom));
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = n_sent + n;
    while (n_sent < stop) run_walk();
  endtask

  initial begin
    n_sent = 0; calm = 0; hold_off = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: bare mode at reset values, then sv39 corner cases
    offer(mk(ACT_START, '1, KIND_LOAD, PRIV_U, '0, 0));
    offer(mk(ACT_RESP, '0, KIND_LOAD, PRIV_U, '1, 1));
    set_all(4'd8, 44'h0_0000_0010, 0, 1, 1, 4'hF, 4'hF, 3'd5);
    offer(mk(ACT_START, 64'h0000_0000_0000_0000, KIND_FETCH, PRIV_M, '0, 0));
    offer(mk(ACT_START, 64'h8000_0000_0000_0000, KIND_LOAD, PRIV_S, '0, 0));
    offer(mk(ACT_START, '1, KIND_STORE, PRIV_U, '0, 0));
    // pointer, pointer, user leaf seen as S without sum -> fault, stray ack
    offer(mk(ACT_START, 64'h0000_0000_1234_5678, KIND_STORE, PRIV_M, '0, 0));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h0000_0000_0000_0401, 0));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h0000_0000_0000_0801, 0));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h0000_0000_0004_0017, 0));
    offer(mk(ACT_ACK, '0, '0, '0, '0, 0));
    // ack with memory error, reserved bits, drop mid-walk, action none
    offer(mk(ACT_START, 64'h0000_0000_0000_1000, KIND_AMO, PRIV_S, '0, 0));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h0000_0000_0000_000F, 0));
    offer(mk(ACT_ACK, '0, '0, '0, '0, 1));
    offer(mk(ACT_START, 64'h0000_0000_0000_2000, KIND_CBO, PRIV_U, '0, 0));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h1FC0_0000_0000_00CF, 0));
    offer(mk(ACT_START, 64'h0000_0000_0000_3000, 3'd7, PRIV_M, '0, 0));
    offer(mk(ACT_START, 64'h0000_0000_0000_4000, KIND_LOAD, 2'd2, '0, 0));
    offer(mk(ACT_NONE, '1, '1, '1, '1, 1));
    offer(mk(ACT_RESP, '0, '0, '0, 64'h8000_0000_0000_20CB, 0));

    // random phases across settings, extremes included
    set_all(4'd8, '1, 1, 0, 0, 4'h0, 4'h0, 3'd0);
    random_phase(90);
    set_all(4'd9, $urandom, $urandom, $urandom, 1, 4'hF, $urandom, $urandom);
    calm = 1;
    random_phase(90);
    calm = 0;
    // long receiver hold-off while requests keep coming
    set_all(4'd10, '0, 1, 1, 1, $urandom, $urandom, 3'd7);
    hold_off = 80;
    random_phase(110);
    set_all(4'd15, $urandom, 0, 0, 1, 4'hF, 4'hA, 3'd4);
    random_phase(40);
    set_all(4'd8, $urandom, $urandom, $urandom, $urandom, 4'hF, 4'hF, 3'd6);
    random_phase(110);
    set_all(4'd10, $urandom, $urandom, $urandom, 1, 4'h7, 4'h5, $urandom);
    random_phase(110);
    set_all(4'd9, {$urandom, $urandom}, 0, 1, 0, 4'hB, 4'hE, 3'd1);
    random_phase(110);
    set_all(4'd0, $urandom, 1, 1, 1, 4'h8, 4'hF, 3'd4);
    random_phase(40);

    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests over bare, pass-through and sv39/48/57 settings",
             n_sent);
    $display("results seen: %0d reads, %0d write-backs, %0d done, %0d faults",
             sb.n_read, sb.n_write, sb.n_done, sb.n_fault);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** page_table_walker_core: PASSED **");
    end else begin
      $display("** page_table_walker_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ptw_pkg.sv
hdl/ptw_queue.sv
hdl/ptw_back.sv
hdl/page_table_walker_core.sv
hdl/ptw_checker.sv
tb/sv/page_table_walker_core_tb.sv
